/* src/vtdt_pkg.sv */
// Shared types and constants of the vertex triple deduplication table.
`timescale 1ns / 1ps

package vtdt_pkg;

	localparam int unsigned FIELD_W          = 20;
	localparam int unsigned UIDX_W           = 10;
	localparam int unsigned DEF_TABLE_DEPTH  = 1024;
	localparam int unsigned DEF_INDEX_WIDTH  = 20;

	typedef enum logic {
		KIND_VERTEX = 1'b0,
		KIND_CLEAR  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] position_index;
		logic [FIELD_W-1:0] texcoord_index;
		logic [FIELD_W-1:0] normal_index;
		logic               face_end;
	} in_item_t;

	typedef struct packed {
		logic [UIDX_W-1:0] unique_index;
		logic              newly_added;
		logic              overflow;
		logic              face_end_out;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} srch_state_t;

	// start request from the front end to the search sequencer
	typedef struct packed {
		logic     start;
		in_item_t item;
	} srch_req_t;

	// status and result from the search sequencer
	typedef struct packed {
		logic      idle;
		logic      valid;
		out_item_t item;
	} srch_rsp_t;

endpackage

/* src/vtdt_if.sv */
// Valid/ready channel interfaces for vertex items and result items.
`timescale 1ns / 1ps

interface vtdt_in_if;
	logic               valid;
	logic               ready;
	vtdt_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vtdt_out_if;
	logic                valid;
	logic                ready;
	vtdt_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/vtdt_search.sv */
// Triple table with a sequential search through one shared comparator.
`timescale 1ns / 1ps

module vtdt_search #(
	parameter int unsigned TABLE_DEPTH = vtdt_pkg::DEF_TABLE_DEPTH,
	parameter int unsigned INDEX_WIDTH = vtdt_pkg::DEF_INDEX_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vtdt_pkg::srch_req_t req,
	input  logic                out_free,
	output vtdt_pkg::srch_rsp_t rsp
);
	import vtdt_pkg::*;

	localparam int unsigned AW     = $clog2(TABLE_DEPTH);
	localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned USED_W = (INDEX_WIDTH < FIELD_W) ? INDEX_WIDTH : FIELD_W;
	localparam int unsigned KW     = 3 * USED_W;
	localparam int unsigned EXT_W  = (AW > UIDX_W) ? AW : UIDX_W;

	logic [KW-1:0] mem [TABLE_DEPTH];

	srch_state_t   state_q, state_d;
	logic [KW-1:0] key_q;
	logic          face_end_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;
	logic          cmp_vld_q;
	logic [AW-1:0] cmp_idx_q;
	logic [KW-1:0] rd_data_q;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;

	logic             start_vtx, start_clr;
	logic             issue, match, last_cmp, full, commit, append;
	logic [KW-1:0]    req_key;
	logic [AW-1:0]    idx_sel;
	logic [EXT_W-1:0] idx_ext;

	assign req_key = {req.item.position_index[USED_W-1:0],
		req.item.texcoord_index[USED_W-1:0],
		req.item.normal_index[USED_W-1:0]};

	assign start_vtx = (state_q == S_IDLE) && req.start && (req.item.kind == KIND_VERTEX);
	assign start_clr = (state_q == S_IDLE) && req.start && (req.item.kind == KIND_CLEAR);
	assign issue     = (state_q == S_SEARCH) && (issue_q < count_q);
	assign match     = (state_q == S_SEARCH) && cmp_vld_q && (rd_data_q == key_q);
	assign last_cmp  = (state_q == S_SEARCH) && cmp_vld_q &&
		((CW'(cmp_idx_q) + CW'(1)) == count_q);
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign commit    = (state_q == S_FINISH) && out_free;
	assign append    = commit && !hit_q && !full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start_vtx) begin
					state_d = (count_q == '0) ? S_FINISH : S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (match || last_cmp) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		idx_sel = hit_q ? hit_idx_q : count_q[AW-1:0];
		idx_ext = EXT_W'(idx_sel);
		rsp.idle               = (state_q == S_IDLE);
		rsp.valid              = (state_q == S_FINISH);
		rsp.item.newly_added   = !hit_q && !full;
		rsp.item.overflow      = !hit_q && full;
		rsp.item.face_end_out  = face_end_q;
		rsp.item.unique_index  = (!hit_q && full) ? '0 : idx_ext[UIDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			issue_q   <= '0;
			cmp_vld_q <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= issue;
			if (start_clr) begin
				count_q <= '0;
			end else if (append) begin
				count_q <= count_q + CW'(1);
			end
			if (start_vtx) begin
				issue_q <= '0;
				hit_q   <= 1'b0;
			end else begin
				if (issue) begin
					issue_q <= issue_q + CW'(1);
				end
				if (match || last_cmp) begin
					hit_q <= match;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_vtx) begin
			key_q      <= req_key;
			face_end_q <= req.item.face_end;
		end
		if (match || last_cmp) begin
			hit_idx_q <= cmp_idx_q;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (append) begin
			mem[count_q[AW-1:0]] <= key_q;
		end
		if (issue) begin
			rd_data_q <= mem[issue_q[AW-1:0]];
			cmp_idx_q <= issue_q[AW-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_q |-> (CW'(cmp_idx_q) < count_q))
		else $error("compare of an entry beyond the fill count");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.item.overflow) |-> (count_q == CW'(TABLE_DEPTH)))
		else $error("overflow flagged with room in the table");

	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after commit");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		append |=> (count_q == $past(count_q) + CW'(1)))
		else $error("append did not advance the entry count");
`endif

endmodule

/* src/vertex_triple_dedup_table_unit.sv */
// Top level of the vertex triple deduplication table.
`timescale 1ns / 1ps

// Deduplicates mesh face vertices. Each vertex item carries a position,
// texture-coordinate and normal index; the unit searches its table of unique
// triples oldest first, one entry per cycle through a single comparator fed
// by the table memory's registered read port. On the first match it returns
// that entry's index; otherwise it appends the triple and returns the new
// index with newly_added set. With the table full and no match the triple is
// dropped and the result carries overflow with index 0. A clear item empties
// the table and gives no result. face_end is copied through. A search stops
// at the first matching entry; a miss compares every stored entry, and on an
// empty table no search is made. The unit takes no new item during a search.
// Results sit in an output register, so the next item is accepted while a
// finished result waits to be taken. Only the low INDEX_WIDTH bits of each
// index are compared and stored.
module vertex_triple_dedup_table_unit #(
	parameter int unsigned TABLE_DEPTH = vtdt_pkg::DEF_TABLE_DEPTH,
	parameter int unsigned INDEX_WIDTH = vtdt_pkg::DEF_INDEX_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	vtdt_in_if.sink           vertex,
	vtdt_out_if.source        result
);
	import vtdt_pkg::*;

	srch_req_t req;
	srch_rsp_t rsp;
	logic      out_free;
	logic      out_load;
	logic      out_valid_q;
	out_item_t out_q;

	// take an item only while the search sequencer is idle
	assign vertex.ready = rsp.idle;
	assign req          = '{start: vertex.valid && vertex.ready, item: vertex.data};

	// output register frees up when empty or being drained this cycle
	assign out_free = !out_valid_q || result.ready;
	assign out_load = rsp.valid && out_free;

	vtdt_search #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.rsp      (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the sink takes it
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= rsp.item;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result lost or changed");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !vertex.ready)
		else $error("item accepted while a result is being finished");
`endif

endmodule
